@@ rtl/bba_pkg.sv @@
package bba_pkg;

   // defaults for the top-level parameters
   localparam int MAX_BLOCKS_DEF = 65536;
   localparam int WORD_BITS_DEF  = 32;

   // fixed field widths
   localparam int BLOCK_W    = 17;
   localparam int OFFSET_W   = 16;
   localparam int COUNT_W    = 17;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 17;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 17'h10000;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2,
      STATUS_FREE  = 2'd3
   } status_type;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COUNT  = 1'b0,
      CSR_OFFSET = 1'b1
   } csr_index_type;

   // memory port strobes from the sequencer to the bitmap store
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

endpackage

@@ rtl/bba_req_if.sv @@
interface bba_req_if import bba_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               kind;
   logic [BLOCK_W-1:0] block_number;

   modport source (output valid, kind, block_number, input ready);
   modport sink   (input valid, kind, block_number, output ready);
endinterface

@@ rtl/bba_rsp_if.sv @@
interface bba_rsp_if import bba_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [BLOCK_W-1:0]  allocated_block;
   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0]  used_count;

   modport source (output valid, allocated_block, status, used_count, input ready);
   modport sink   (input valid, allocated_block, status, used_count, output ready);
endinterface

@@ rtl/bba_bitmap.sv @@
module bba_bitmap import bba_pkg::*; #(
   parameter int WORD_BITS = WORD_BITS_DEF,
   parameter int DEPTH     = 2048,
   parameter int AW        = 11
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mem_ctl_type          mem_ctl,
   input  logic [AW-1:0]        rd_addr,
   input  logic [AW-1:0]        wr_addr,
   input  logic [WORD_BITS-1:0] wr_data,
   output logic [WORD_BITS-1:0] rd_data
);

   localparam int PW = $clog2(DEPTH + 1);

   logic [WORD_BITS-1:0] mem [DEPTH];
   logic [WORD_BITS-1:0] raw_ff;
   logic                 known_ff;
   logic                 known_in;
   logic [PW-1:0]        fill_ff;
   logic [PW-1:0]        fill_in;

   // Words are written in order from 0 upward, so everything at or above the
   // fill count was never written and reads as all free.
   always_comb begin
      fill_in = fill_ff;
      if (mem_ctl.wr_en && (PW'(wr_addr) >= fill_ff)) begin
         fill_in = PW'(wr_addr) + PW'(1);
      end
      known_in = known_ff;
      if (mem_ctl.rd_en) begin
         known_in = PW'(rd_addr) < fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         known_ff <= 1'b0;
      end else begin
         fill_ff  <= fill_in;
         known_ff <= known_in;
      end
   end

   // storage: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (mem_ctl.rd_en) begin
         raw_ff <= mem[rd_addr];
      end
   end

   assign rd_data = known_ff ? raw_ff : '0;

endmodule

@@ rtl/bba_ctrl.sv @@
module bba_ctrl import bba_pkg::*; #(
   parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
   parameter int WORD_BITS  = WORD_BITS_DEF,
   parameter int DEPTH      = 2048,
   parameter int AW         = 11
) (
   input  logic                  clock,
   input  logic                  reset,
   bba_req_if.sink               req_chan,
   bba_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output mem_ctl_type           mem_ctl,
   output logic [AW-1:0]         rd_addr,
   output logic [AW-1:0]         wr_addr,
   output logic [WORD_BITS-1:0]  wr_data,
   input  logic [WORD_BITS-1:0]  rd_data
);

   localparam int PW        = $clog2(DEPTH + 1);
   localparam int BASE_W    = $clog2(DEPTH * WORD_BITS + WORD_BITS + 1);
   localparam int BIT_W     = $clog2(WORD_BITS);
   // index / WORD_BITS by reciprocal multiply, off by at most one low
   localparam int DIV_SHIFT = 24;
   localparam int RECIP     = (1 << DIV_SHIFT) / WORD_BITS;
   localparam int RECIP_W   = $clog2(RECIP + 1);
   localparam int PROD_W    = BLOCK_W + RECIP_W;
   localparam int QW        = PROD_W - DIV_SHIFT;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SCAN   = 6'b000010,
      ST_FCHECK = 6'b000100,
      ST_FSPLIT = 6'b001000,
      ST_FDATA  = 6'b010000,
      ST_RESP   = 6'b100000
   } state_type;

   state_type            state_ff, state_in;
   logic [BLOCK_W-1:0]   bnum_ff, bnum_in;
   logic [COUNT_W-1:0]   cnt_cfg_ff, cnt_cfg_in;
   logic [OFFSET_W-1:0]  off_ff, off_in;
   logic [COUNT_W-1:0]   used_ff, used_in;
   logic [PW-1:0]        ptr_ff, ptr_in;
   logic [BASE_W-1:0]    base_ff, base_in;
   logic                 pend_ff, pend_in;
   logic [AW-1:0]        pend_addr_ff, pend_addr_in;
   logic [BASE_W-1:0]    pend_base_ff, pend_base_in;
   logic [BLOCK_W-1:0]   idx_ff, idx_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [BIT_W-1:0]     bit_ff, bit_in;
   logic [BLOCK_W-1:0]   res_blk_ff, res_blk_in;
   status_type           res_st_ff, res_st_in;
   logic                 out_valid_ff, out_valid_in;
   logic [BLOCK_W-1:0]   out_blk_ff, out_blk_in;
   logic [STATUS_W-1:0]  out_st_ff, out_st_in;
   logic [COUNT_W-1:0]   out_used_ff, out_used_in;

   logic [COUNT_W-1:0]   eff_cnt;
   logic [31:0]          limit;
   logic [WORD_BITS-1:0] allowed;
   logic [WORD_BITS-1:0] free_vec;
   logic                 found;
   logic [BIT_W-1:0]     hit_bit;
   logic                 issue;
   logic [BLOCK_W-1:0]   idx_sub;
   logic                 out_of_range;
   logic [QW-1:0]        q_est;
   logic [QW-1:0]        q_fix;
   logic [31:0]          rem;
   logic [31:0]          rem_fix;
   logic                 load_out;

   // a count above capacity acts as capacity
   assign eff_cnt = (32'(cnt_cfg_ff) > 32'(MAX_BLOCKS)) ? COUNT_W'(MAX_BLOCKS) : cnt_cfg_ff;

   // clear bits of the word in hand that lie below the block count
   always_comb begin
      limit = 32'(eff_cnt) - 32'(pend_base_ff);
      for (int b = 0; b < WORD_BITS; b++) begin
         allowed[b] = 32'(b) < limit;
      end
      free_vec = ~rd_data & allowed;
      found    = |free_vec;
      hit_bit  = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (free_vec[b]) begin
            hit_bit = BIT_W'(b);
         end
      end
   end

   // free: index, range check, word and bit split
   always_comb begin
      idx_sub      = bnum_ff - BLOCK_W'(off_ff);
      out_of_range = (bnum_ff < BLOCK_W'(off_ff)) || (idx_sub >= eff_cnt);
      q_est        = prod_ff[PROD_W-1:DIV_SHIFT];
      rem          = 32'(idx_ff) - 32'(q_est) * 32'(WORD_BITS);
      q_fix        = q_est;
      rem_fix      = rem;
      if (rem >= 32'(WORD_BITS)) begin
         q_fix   = q_est + QW'(1);
         rem_fix = rem - 32'(WORD_BITS);
      end
   end

   assign issue    = (32'(base_ff) < 32'(eff_cnt)) && !(pend_ff && found);
   assign load_out = (state_ff == ST_RESP) && (!out_valid_ff || rsp_chan.ready);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      bnum_in      = bnum_ff;
      used_in      = used_ff;
      ptr_in       = ptr_ff;
      base_in      = base_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      pend_base_in = pend_base_ff;
      idx_in       = idx_ff;
      prod_in      = prod_ff;
      bit_in       = bit_ff;
      res_blk_in   = res_blk_ff;
      res_st_in    = res_st_ff;
      mem_ctl      = '0;
      rd_addr      = AW'(ptr_ff);
      wr_addr      = pend_addr_ff;
      wr_data      = rd_data | (WORD_BITS'(1) << hit_bit);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               bnum_in    = req_chan.block_number;
               res_blk_in = '0;
               ptr_in     = '0;
               base_in    = '0;
               state_in   = req_chan.kind ? ST_FCHECK : ST_SCAN;
            end
         end
         ST_SCAN: begin
            // read one word a cycle, test the word read the cycle before
            if (issue) begin
               mem_ctl.rd_en = 1'b1;
               pend_in       = 1'b1;
               pend_addr_in  = AW'(ptr_ff);
               pend_base_in  = base_ff;
               ptr_in        = ptr_ff + PW'(1);
               base_in       = base_ff + BASE_W'(WORD_BITS);
            end
            if (pend_ff && found) begin
               mem_ctl.wr_en = 1'b1;
               used_in       = used_ff + COUNT_W'(1);
               res_blk_in    = BLOCK_W'(off_ff) + BLOCK_W'(pend_base_ff) + BLOCK_W'(hit_bit);
               res_st_in     = STATUS_OK;
               state_in      = ST_RESP;
            end else if (!pend_ff && !issue) begin
               res_st_in = STATUS_FULL;
               state_in  = ST_RESP;
            end
         end
         ST_FCHECK: begin
            idx_in  = idx_sub;
            prod_in = PROD_W'(idx_sub) * PROD_W'(RECIP);
            if (out_of_range) begin
               res_st_in = STATUS_RANGE;
               state_in  = ST_RESP;
            end else begin
               state_in = ST_FSPLIT;
            end
         end
         ST_FSPLIT: begin
            mem_ctl.rd_en = 1'b1;
            rd_addr       = AW'(q_fix);
            pend_addr_in  = AW'(q_fix);
            bit_in        = BIT_W'(rem_fix);
            state_in      = ST_FDATA;
         end
         ST_FDATA: begin
            wr_data = rd_data & ~(WORD_BITS'(1) << bit_ff);
            if (rd_data[bit_ff]) begin
               mem_ctl.wr_en = 1'b1;
               if (used_ff != '0) begin
                  used_in = used_ff - COUNT_W'(1);
               end
               res_st_in = STATUS_OK;
            end else begin
               res_st_in = STATUS_FREE;
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output word register
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_blk_in   = out_blk_ff;
      out_st_in    = out_st_ff;
      out_used_in  = out_used_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
         out_blk_in   = res_blk_ff;
         out_st_in    = res_st_ff;
         out_used_in  = used_ff;
      end
   end

   // configuration writes
   always_comb begin
      cnt_cfg_in = cnt_cfg_ff;
      off_in     = off_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_COUNT:  cnt_cfg_in = csr_wdata;
            CSR_OFFSET: off_in     = csr_wdata[OFFSET_W-1:0];
            default:    cnt_cfg_in = cnt_cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         cnt_cfg_ff   <= COUNT_RESET;
         off_ff       <= '0;
         ptr_ff       <= '0;
         base_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
         cnt_cfg_ff   <= cnt_cfg_in;
         off_ff       <= off_in;
         ptr_ff       <= ptr_in;
         base_ff      <= base_in;
      end
   end

   always_ff @(posedge clock) begin
      bnum_ff      <= bnum_in;
      pend_addr_ff <= pend_addr_in;
      pend_base_ff <= pend_base_in;
      idx_ff       <= idx_in;
      prod_ff      <= prod_in;
      bit_ff       <= bit_in;
      res_blk_ff   <= res_blk_in;
      res_st_ff    <= res_st_in;
      out_blk_ff   <= out_blk_in;
      out_st_ff    <= out_st_in;
      out_used_ff  <= out_used_in;
   end

   assign req_chan.ready           = (state_ff == ST_IDLE);
   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.allocated_block = out_blk_ff;
   assign rsp_chan.status          = out_st_ff;
   assign rsp_chan.used_count      = out_used_ff;

endmodule

@@ rtl/bitmap_block_allocator.sv @@
// First-fit block allocator over a used-block bitmap held in one synchronous
// memory of MAX_BLOCKS/WORD_BITS words; every block is free after reset with no
// clearing pass (a fill count marks which words were ever written). One
// request is in work at a time, and the next can be taken while the previous
// result word still waits on the response channel. An allocate reads one bitmap
// word per cycle through the memory read port from word 0 up to the first word
// with a free block below the block count, or to the end of the count when the
// map is full. A free goes through range check with a reciprocal multiply, word
// and bit split with the read, write-back, and the result register; a free
// outside the data region goes from the range check straight to the result
// register. Status 0 ok, 1 no free block, 2 block outside the data region,
// 3 block already free.
module bitmap_block_allocator import bba_pkg::*; #(
   parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
   parameter int WORD_BITS  = WORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   bba_req_if.sink               req_chan,
   bba_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int DEPTH = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   mem_ctl_type          mem_ctl;
   logic [AW-1:0]        rd_addr;
   logic [AW-1:0]        wr_addr;
   logic [WORD_BITS-1:0] wr_data;
   logic [WORD_BITS-1:0] rd_data;

   // request sequencer, configuration and result register
   bba_ctrl #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .WORD_BITS  (WORD_BITS),
      .DEPTH      (DEPTH),
      .AW         (AW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .mem_ctl   (mem_ctl),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_data   (rd_data)
   );

   // bitmap store
   bba_bitmap #(
      .WORD_BITS (WORD_BITS),
      .DEPTH     (DEPTH),
      .AW        (AW)
   ) u_bitmap (
      .clock   (clock),
      .reset   (reset),
      .mem_ctl (mem_ctl),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

endmodule

@@ tb/sv/tb_bitmap_block_allocator.sv @@
`timescale 1ns / 100ps

module tb_bitmap_block_allocator;
   import bba_pkg::*;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;
   localparam int   SETTLE     = 8;
   localparam int   LIMIT      = 400000;
   localparam int   SEGMENTS   = 8;
   localparam int   SEG_ITEMS  = 60;

   // one result word as the block returns it
   typedef struct packed {
      logic [BLOCK_W-1:0] block;
      status_type         status;
      logic [COUNT_W-1:0] used;
   } grant_word_type;

   // one directed step: either a register setting or a request
   typedef struct {
      bit                    is_cfg;
      logic                  kind;
      logic [BLOCK_W-1:0]    bnum;
      logic [CSR_DATA_W-1:0] cnt;
      logic [CSR_DATA_W-1:0] off;
      bit                    typed;
      grant_word_type        want;
   } step_row_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   bba_req_if req_bus ();
   bba_rsp_if rsp_bus ();

   bitmap_block_allocator u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // allocator shadow state
   bit                 used_map [MAX_BLOCKS_DEF];
   int                 in_use;
   logic [COUNT_W-1:0] cfg_count;
   logic [OFFSET_W-1:0] cfg_offset;
   int                 granted_idx[$];
   int                 released_idx[$];

   grant_word_type pending_results[$];
   step_row_type   directed_rows[$];

   int send_idle_pct;
   int recv_stall_pct;
   int fail_count;
   int cycle_count;
   int sent_count;
   int checked_count;
   int csr_writes;
   int status_hits [4];

   // clock
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("bitmap_block_allocator regression: fail");
         $finish;
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // result checker
   always @(posedge clock) begin
      grant_word_type exp_w;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         status_hits[rsp_bus.status] = status_hits[rsp_bus.status] + 1;
         if (pending_results.size() == 0) begin
            $error("result word with nothing expected: block %0d status %0d used %0d",
                   rsp_bus.allocated_block, rsp_bus.status, rsp_bus.used_count);
            fail_count = fail_count + 1;
         end else begin
            exp_w = pending_results.pop_front();
            checked_count = checked_count + 1;
            if (rsp_bus.allocated_block !== exp_w.block) begin
               $error("allocated_block: expected %0d, actual %0d",
                      exp_w.block, rsp_bus.allocated_block);
               fail_count = fail_count + 1;
            end
            if (rsp_bus.status !== exp_w.status) begin
               $error("status: expected %0d, actual %0d", exp_w.status, rsp_bus.status);
               fail_count = fail_count + 1;
            end
            if (rsp_bus.used_count !== exp_w.used) begin
               $error("used_count: expected %0d, actual %0d", exp_w.used, rsp_bus.used_count);
               fail_count = fail_count + 1;
            end
         end
      end
   end

   // first-fit allocate / free on the shadow bitmap
   task automatic model_request(input logic k, input logic [BLOCK_W-1:0] bn,
                                output grant_word_type r);
      int eff;
      int idx;
      int i;
      eff = (cfg_count > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : int'(cfg_count);
      r.block  = '0;
      r.status = STATUS_OK;
      if (k == KIND_ALLOC) begin
         r.status = STATUS_FULL;
         for (i = 0; i < eff; i++) begin
            if (!used_map[i]) begin
               used_map[i] = 1'b1;
               in_use      = in_use + 1;
               r.block     = BLOCK_W'(int'(cfg_offset) + i);
               r.status    = STATUS_OK;
               granted_idx.push_back(i);
               break;
            end
         end
      end else if (bn < cfg_offset) begin
         r.status = STATUS_RANGE;
      end else begin
         idx = int'(bn) - int'(cfg_offset);
         if (idx >= eff) begin
            r.status = STATUS_RANGE;
         end else if (!used_map[idx]) begin
            r.status = STATUS_FREE;
         end else begin
            used_map[idx] = 1'b0;
            if (in_use > 0) in_use = in_use - 1;
            foreach (granted_idx[j]) begin
               if (granted_idx[j] == idx) begin
                  granted_idx.delete(j);
                  break;
               end
            end
            released_idx.push_back(idx);
            if (released_idx.size() > 8) void'(released_idx.pop_front());
         end
      end
      r.used = COUNT_W'(in_use);
   endtask

   // entered and left at a falling edge; valid stays up between back-to-back words
   task automatic send_request(input logic k, input logic [BLOCK_W-1:0] bn,
                               input bit typed, input grant_word_type want);
      grant_word_type got;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.kind         <= k;
      req_bus.block_number <= bn;
      do @(posedge clock); while (!req_bus.ready);
      model_request(k, bn, got);
      pending_results.push_back(typed ? want : got);
      sent_count = sent_count + 1;
      @(negedge clock);
   endtask

   // stop sending until every result word is back, then let the block settle
   task automatic drain(input int settle);
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (pending_results.size() != 0);
      repeat (settle) @(negedge clock);
   endtask

   // both registers, one per cycle, only while idle
   task automatic write_config(input logic [CSR_DATA_W-1:0] cnt,
                               input logic [CSR_DATA_W-1:0] off);
      csr_we    <= 1'b1;
      csr_index <= CSR_COUNT;
      csr_wdata <= cnt;
      cfg_count  = cnt;
      @(negedge clock);
      csr_index <= CSR_OFFSET;
      csr_wdata <= off;
      cfg_offset = off[OFFSET_W-1:0];
      @(negedge clock);
      csr_we    <= 1'b0;
      csr_writes = csr_writes + 2;
   endtask

   task automatic set_phase(input int ph);
      case (ph % 4)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
         default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
   endtask

   function automatic step_row_type cfg_row(input logic [CSR_DATA_W-1:0] cnt,
                                            input logic [CSR_DATA_W-1:0] off);
      step_row_type s;
      s.is_cfg = 1'b1;
      s.kind   = KIND_ALLOC;
      s.bnum   = '0;
      s.cnt    = cnt;
      s.off    = off;
      s.typed  = 1'b0;
      s.want   = '0;
      return s;
   endfunction

   function automatic step_row_type req_row(input logic k, input logic [BLOCK_W-1:0] bn);
      step_row_type s;
      s        = cfg_row('0, '0);
      s.is_cfg = 1'b0;
      s.kind   = k;
      s.bnum   = bn;
      return s;
   endfunction

   function automatic step_row_type chk_row(input logic k, input logic [BLOCK_W-1:0] bn,
                                            input logic [BLOCK_W-1:0] blk,
                                            input status_type st,
                                            input logic [COUNT_W-1:0] used);
      step_row_type s;
      s             = req_row(k, bn);
      s.typed       = 1'b1;
      s.want.block  = blk;
      s.want.status = st;
      s.want.used   = used;
      return s;
   endfunction

   // stimulus
   initial begin
      step_row_type       row;
      grant_word_type     none;
      logic               k;
      logic [BLOCK_W-1:0] bn;
      logic [CSR_DATA_W-1:0] cnt;
      logic [CSR_DATA_W-1:0] off;
      int                 pick;
      int                 idx;
      int                 n_directed;

      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.kind         = KIND_ALLOC;
      req_bus.block_number = '0;
      rsp_bus.ready        = 1'b0;
      csr_we               = 1'b0;
      csr_index            = CSR_COUNT;
      csr_wdata            = '0;
      cfg_count            = COUNT_RESET;
      cfg_offset           = '0;
      in_use               = 0;
      fail_count           = 0;
      cycle_count          = 0;
      sent_count           = 0;
      checked_count        = 0;
      csr_writes           = 0;
      status_hits          = '{0, 0, 0, 0};
      none                 = '0;
      set_phase(0);

      // after reset: count 65536, offset 0, empty map
      directed_rows.push_back(chk_row(KIND_ALLOC, 17'd0,      17'd0,     STATUS_OK,    17'd1));
      directed_rows.push_back(chk_row(KIND_ALLOC, 17'd0,      17'd1,     STATUS_OK,    17'd2));
      directed_rows.push_back(chk_row(KIND_FREE,  17'd0,      17'd0,     STATUS_OK,    17'd1));
      // double free
      directed_rows.push_back(chk_row(KIND_FREE,  17'd0,      17'd0,     STATUS_FREE,  17'd1));
      // first fit takes the hole again
      directed_rows.push_back(chk_row(KIND_ALLOC, 17'd0,      17'd0,     STATUS_OK,    17'd2));
      directed_rows.push_back(chk_row(KIND_FREE,  17'h1FFFF,  17'd0,     STATUS_RANGE, 17'd2));
      directed_rows.push_back(chk_row(KIND_FREE,  17'h10000,  17'd0,     STATUS_RANGE, 17'd2));
      // tiny map, top offset (bit 16 of the data dropped)
      directed_rows.push_back(cfg_row(17'd3, 17'h1FFFF));
      directed_rows.push_back(chk_row(KIND_FREE,  17'd0,      17'd0,     STATUS_RANGE, 17'd2));
      directed_rows.push_back(chk_row(KIND_ALLOC, 17'd0,      17'd65537, STATUS_OK,    17'd3));
      // map full
      directed_rows.push_back(chk_row(KIND_ALLOC, 17'd0,      17'd0,     STATUS_FULL,  17'd3));
      directed_rows.push_back(chk_row(KIND_FREE,  17'd65536,  17'd0,     STATUS_OK,    17'd2));
      directed_rows.push_back(chk_row(KIND_ALLOC, 17'd0,      17'd65536, STATUS_OK,    17'd3));
      // zero count: nothing to give, held blocks now out of range
      directed_rows.push_back(cfg_row(17'd0, 17'd0));
      directed_rows.push_back(chk_row(KIND_ALLOC, 17'd0,      17'd0,     STATUS_FULL,  17'd3));
      directed_rows.push_back(chk_row(KIND_FREE,  17'd0,      17'd0,     STATUS_RANGE, 17'd3));
      // count above capacity clamps to the full map
      directed_rows.push_back(cfg_row(17'h1FFFF, 17'd100));
      directed_rows.push_back(chk_row(KIND_ALLOC, 17'h1FFFF,  17'd103,   STATUS_OK,    17'd4));
      directed_rows.push_back(chk_row(KIND_FREE,  17'd102,    17'd0,     STATUS_OK,    17'd3));
      directed_rows.push_back(chk_row(KIND_FREE,  17'd99,     17'd0,     STATUS_RANGE, 17'd3));
      directed_rows.push_back(chk_row(KIND_FREE,  17'd65636,  17'd0,     STATUS_RANGE, 17'd3));
      // map spanning two words
      directed_rows.push_back(cfg_row(17'd34, 17'd0));
      directed_rows.push_back(req_row(KIND_ALLOC, 17'h0AAAA));
      directed_rows.push_back(req_row(KIND_FREE,  17'd33));
      directed_rows.push_back(req_row(KIND_FREE,  17'd34));
      directed_rows.push_back(req_row(KIND_FREE,  17'd3));

      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         if (row.is_cfg) begin
            drain(SETTLE);
            write_config(row.cnt, row.off);
         end else begin
            send_request(row.kind, row.bnum, row.typed, row.want);
         end
      end
      n_directed = sent_count;

      // random segments, each with its own register setting and idle pattern
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         drain(SETTLE);
         case ($urandom_range(9))
            0:       cnt = 17'd0;
            1:       cnt = 17'h10000;
            2:       cnt = 17'($urandom_range(131071, 65537));
            default: cnt = 17'($urandom_range(96, 1));
         endcase
         if (seg == 0) cnt = 17'd40;
         case ($urandom_range(3))
            0:       off = {1'($urandom_range(1)), 16'h0000};
            1:       off = {1'($urandom_range(1)), 16'hFFFF};
            default: off = 17'($urandom);
         endcase
         write_config(cnt, off);
         set_phase(seg);
         for (int n = 0; n < SEG_ITEMS; n++) begin
            // hold off now and then until the pipe is empty
            if ($urandom_range(39) == 0) drain(0);
            pick = $urandom_range(99);
            k    = KIND_FREE;
            bn   = 17'($urandom);
            if (pick < 45) begin
               k = KIND_ALLOC;
            end else if (pick < 80) begin
               if (granted_idx.size() == 0) begin
                  k = KIND_ALLOC;
               end else begin
                  idx = granted_idx[$urandom_range(granted_idx.size() - 1)];
                  bn  = BLOCK_W'(int'(cfg_offset) + idx);
               end
            end else if (pick < 88) begin
               if (released_idx.size() != 0)
                  idx = released_idx[$urandom_range(released_idx.size() - 1)];
               else
                  idx = $urandom_range(127);
               bn = BLOCK_W'(int'(cfg_offset) + idx);
            end
            send_request(k, bn, 1'b0, none);
         end
      end

      drain(SETTLE);
      $display("covered %0d requests (%0d directed), %0d result words, %0d register writes",
               sent_count, n_directed, checked_count, csr_writes);
      $display("status mix: ok %0d, no free block %0d, out of region %0d, already free %0d",
               status_hits[0], status_hits[1], status_hits[2], status_hits[3]);
      if (fail_count == 0) begin
         $display("bitmap_block_allocator regression: pass");
      end else begin
         $display("bitmap_block_allocator regression: fail");
      end
      $finish;
   end

endmodule
